// ----- src/ahfd_pkg.sv -----
// Shared types, character codes and the hex nibble helper for the ASCII hex frame decoder.
// Depends on nothing; ascii_hex_frame_decoder_core imports it.
package ahfd_pkg;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_DATA = 2'd1,
      KIND_EOL  = 2'd2
   } kind_type;

   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_COLON = 8'd58;
   localparam logic [7:0] CHAR_DIG0  = 8'd48;
   localparam logic [7:0] CHAR_DIG9  = 8'd57;
   localparam logic [7:0] CHAR_UPA   = 8'd65;
   localparam logic [7:0] CHAR_UPF   = 8'd70;
   localparam logic [7:0] ALPHA_BIAS = 8'd55;

   // Value of an upper-case hex digit; every other character counts as zero.
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] diff;
      diff = 8'd0;
      if (c >= CHAR_DIG0 && c <= CHAR_DIG9) begin
         diff = c - CHAR_DIG0;
      end else if (c >= CHAR_UPA && c <= CHAR_UPF) begin
         diff = c - ALPHA_BIAS;
      end
      return diff[3:0];
   endfunction

endpackage

// ----- src/ascii_hex_frame_decoder_core.sv -----
// Top level of the ASCII hex frame decoder: line state, pair decoding and the result register.
// Depends on ahfd_pkg for the result kind codes, character codes and hex_nibble.

// The decoder takes one received character per transaction and returns exactly one result
// transaction for each, in order. NUL, LF and characters of 0x80 and above are dropped, and
// characters before a ':' are skipped; both give a result of kind "nothing" that carries the
// current count and frame flag. Inside a frame, characters are paired and each pair yields a
// data byte, high nibble first; only '0'-'9' and 'A'-'F' are hex digits and anything else,
// including a second ':', decodes as zero. CR always gives an end-of-line result with the
// line's byte count (modulo 256), discards any unpaired character and returns to idle. The
// line state is updated in the cycle in which the character is accepted, and the result is
// held in a single output register, so a new character is taken every cycle for as long as
// the result side keeps up. The input is stalled only while a result is waiting in that
// register and the result side is itself stalling.
module ascii_hex_frame_decoder_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ahfd_pkg::kind_type rsp_kind,
   output logic [7:0]        rsp_data_byte,
   output logic [7:0]        rsp_byte_count,
   output logic              rsp_frame_open
);
   import ahfd_pkg::*;

   // Line state. The pending character is kept as its nibble plus a flag, which is all the
   // pairing logic ever needs of it.
   logic       in_frame_ff, in_frame_in;
   logic       pending_ff, pending_in;
   logic [3:0] pending_nib_ff, pending_nib_in;
   logic [7:0] count_ff, count_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   kind_type   rsp_kind_ff, kind_in;
   logic [7:0] rsp_data_ff, data_in;
   logic [7:0] rsp_count_ff, rsp_count_in;
   logic       rsp_open_ff, rsp_open_in;

   logic       accept;
   logic       dropped;
   logic [3:0] rx_nib;

   // The result register is free when it is empty or is being emptied in this cycle.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign rx_nib  = hex_nibble(req_rx_byte);
   assign dropped = (req_rx_byte == CHAR_NUL) || (req_rx_byte == CHAR_LF) ||
                    req_rx_byte[7];

   // Next line state and the result that the accepted character causes.
   always_comb begin
      in_frame_in    = in_frame_ff;
      pending_in     = pending_ff;
      pending_nib_in = pending_nib_ff;
      count_in       = count_ff;
      kind_in        = KIND_NONE;
      data_in        = 8'd0;
      rsp_count_in   = count_ff;
      if (dropped) begin
         // State is left untouched.
      end else if (req_rx_byte == CHAR_CR) begin
         kind_in        = KIND_EOL;
         in_frame_in    = 1'b0;
         pending_in     = 1'b0;
         pending_nib_in = 4'd0;
         count_in       = 8'd0;
      end else if (!in_frame_ff) begin
         if (req_rx_byte == CHAR_COLON) begin
            in_frame_in = 1'b1;
            pending_in  = 1'b0;
         end
      end else if (pending_ff) begin
         kind_in      = KIND_DATA;
         data_in      = {pending_nib_ff, rx_nib};
         count_in     = count_ff + 8'd1;
         rsp_count_in = count_in;
         pending_in   = 1'b0;
      end else begin
         pending_in     = 1'b1;
         pending_nib_in = rx_nib;
      end
      rsp_open_in = in_frame_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         pending_ff     <= 1'b0;
         pending_nib_ff <= 4'd0;
         count_ff       <= 8'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            in_frame_ff    <= in_frame_in;
            pending_ff     <= pending_in;
            pending_nib_ff <= pending_nib_in;
            count_ff       <= count_in;
         end
      end
   end

   // Payload of the result register needs no reset; it loads with each accepted character.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_kind_ff  <= kind_in;
         rsp_data_ff  <= data_in;
         rsp_count_ff <= rsp_count_in;
         rsp_open_ff  <= rsp_open_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_data_byte  = rsp_data_ff;
   assign rsp_byte_count = rsp_count_ff;
   assign rsp_frame_open = rsp_open_ff;

`ifndef SYNTHESIS
   // Only a data result carries a non-zero byte.
   a_data_only_on_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff != KIND_DATA) |-> rsp_data_ff == 8'd0)
      else $error("data byte set on a result that is not a data byte");

   // An end of line always closes the frame.
   a_eol_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == KIND_EOL) |-> !rsp_open_ff)
      else $error("frame still open on an end-of-line result");

   // An accepted CR returns the whole line state to idle.
   a_cr_clears: assert property (@(posedge clock) disable iff (reset)
      accept && (req_rx_byte == CHAR_CR) |=>
         !in_frame_ff && !pending_ff && (count_ff == 8'd0))
      else $error("line state not cleared after CR");

   // Each decoded byte advances the line count by one.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      accept && (kind_in == KIND_DATA) |=> count_ff == $past(count_ff) + 8'd1)
      else $error("byte count did not advance on a decoded byte");

   // The input is held off only while a result is waiting.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("input stalled without a waiting result");
`endif

endmodule

// ----- bench/ahfd_result_checker.sv -----
// Result checker for the ASCII hex frame decoder: watches both channels, predicts each result
// and compares it with what the decoder returns. Depends on ahfd_pkg for kinds and characters.
module ahfd_result_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  ahfd_pkg::kind_type rsp_kind,
   input  logic [7:0]         rsp_data_byte,
   input  logic [7:0]         rsp_byte_count,
   input  logic               rsp_frame_open,
   output int                 mismatch_count,
   output int                 results_pending
);
   import ahfd_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [7:0] byte_count;
      logic       frame_open;
   } line_result_type;

   line_result_type awaited_results[$];
   int              bad_results;

   // Predicted line state of the decoder.
   logic         line_open;
   logic [7:0]   held_char;
   logic [7:0]   line_bytes;

   initial begin
      bad_results = 0;
   end

   function automatic logic [3:0] digit_value(input logic [7:0] c);
      if (c >= CHAR_DIG0 && c <= CHAR_DIG9) begin
         return c[3:0];
      end
      if (c >= CHAR_UPA && c <= CHAR_UPF) begin
         return c[3:0] + 4'd9;
      end
      return 4'd0;
   endfunction

   // Advances the predicted line state by one character and gives the result it causes.
   task automatic decode_char(input logic [7:0] c, output line_result_type r);
      r.kind      = KIND_NONE;
      r.data_byte = 8'd0;
      if (c == CHAR_CR) begin
         r.kind       = KIND_EOL;
         r.byte_count = line_bytes;
         r.frame_open = 1'b0;
         line_open    = 1'b0;
         held_char    = 8'd0;
         line_bytes   = 8'd0;
      end else begin
         if (!(c == CHAR_NUL || c == CHAR_LF || c[7])) begin
            if (!line_open) begin
               if (c == CHAR_COLON) begin
                  line_open = 1'b1;
                  held_char = 8'd0;
               end
            end else if (held_char != 8'd0) begin
               r.kind      = KIND_DATA;
               r.data_byte = {digit_value(held_char), digit_value(c)};
               line_bytes  = line_bytes + 8'd1;
               held_char   = 8'd0;
            end else begin
               held_char = c;
            end
         end
         r.byte_count = line_bytes;
         r.frame_open = line_open;
      end
   endtask

   task automatic report_bad(input bit unexpected, input line_result_type want);
      bad_results++;
      if (bad_results <= REPORT_LIMIT) begin
         if (unexpected) begin
            $display("unexpected result: kind %s data %02h count %02h open %b",
                     rsp_kind.name(), rsp_data_byte, rsp_byte_count, rsp_frame_open);
         end else begin
            $display("result mismatch: expected kind %s data %02h count %02h open %b",
                     want.kind.name(), want.data_byte, want.byte_count, want.frame_open);
            $display("                 actual   kind %s data %02h count %02h open %b",
                     rsp_kind.name(), rsp_data_byte, rsp_byte_count, rsp_frame_open);
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      line_result_type oldest;
      line_result_type fresh;
      if (reset) begin
         line_open  = 1'b0;
         held_char  = 8'd0;
         line_bytes = 8'd0;
         awaited_results.delete();
      end else begin
         // The result channel is handled first, so a result never meets an expectation
         // that was only created at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               oldest = '0;
               report_bad(1'b1, oldest);
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_kind !== oldest.kind || rsp_data_byte !== oldest.data_byte ||
                   rsp_byte_count !== oldest.byte_count ||
                   rsp_frame_open !== oldest.frame_open) begin
                  report_bad(1'b0, oldest);
               end
            end
         end
         if (req_valid && !req_stall) begin
            decode_char(req_rx_byte, fresh);
            awaited_results.push_back(fresh);
         end
      end
      mismatch_count  <= bad_results;
      results_pending <= awaited_results.size();
   end

endmodule

// ----- bench/ascii_hex_frame_decoder_core_tb.sv -----
// Top of the testbench for ascii_hex_frame_decoder_core: clock, reset, stimulus and verdict.
// Depends on ahfd_pkg, the decoder itself and ahfd_result_checker beside it.
module ascii_hex_frame_decoder_core_tb;
   import ahfd_pkg::*;

   // About 1750 counted characters are sent over the four phases.
   localparam int CHAR_TARGET = 1750;
   // Length of the deliberate hold-off on the result side, in cycles.
   localparam int LONG_HOLD   = 400;
   // Cycles without any transaction on either channel before the run is given up.
   localparam int QUIET_LIMIT = 3000;
   // Cycles allowed after the last result; the decoder has a single result register.
   localparam int TAIL_CYCLES = 8;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_rx_byte = 8'd0;
   logic       rsp_stall   = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   kind_type   rsp_kind;
   logic [7:0] rsp_data_byte;
   logic [7:0] rsp_byte_count;
   logic       rsp_frame_open;

   int mismatch_count;
   int results_pending;

   // Percentages of cycles in which the sender idles and the receiver stalls; set per phase.
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   // The stimulus raises this count to ask the receiver for one long hold-off.
   int hold_requests      = 0;
   // Characters that the decoder does not simply drop.
   int counted_chars      = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ascii_hex_frame_decoder_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_byte_count (rsp_byte_count),
      .rsp_frame_open (rsp_frame_open)
   );

   ahfd_result_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_frame_open  (rsp_frame_open),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   // The receiver stalls at random in each phase. When a long hold-off is asked for, it counts
   // the cycles itself, so the stimulus is free to keep offering characters meanwhile and the
   // decoder fills its result register and then stalls its input.
   initial begin : receiver
      int hold_left;
      int holds_served;
      hold_left    = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   // The watchdog ends the run when neither channel has moved a transaction for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("ascii_hex_frame_decoder_core_tb failed");
      $finish;
   end

   // Offers one character and returns at the edge that accepts it. Valid is left high, so
   // back-to-back characters keep it high without a glitch; idle cycles are inserted first.
   // Stall is read right after the edge, so its value is the one the decoder saw at that edge.
   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= c;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      if (!(c == CHAR_NUL || c == CHAR_LF || c[7])) begin
         counted_chars++;
      end
   endtask

   // Stops offering and waits until every predicted result has been returned. The first edge
   // is always waited for, since the pending count is written non-blocking at the accepting edge.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (results_pending != 0);
   endtask

   function automatic logic [7:0] hex_char();
      int v;
      v = $urandom_range(15);
      return (v < 10) ? CHAR_DIG0 + 8'(v) : CHAR_UPA + 8'(v - 10);
   endfunction

   // One of the characters the decoder drops: NUL, LF or anything with the top bit set.
   function automatic logic [7:0] dropped_char();
      case ($urandom_range(2))
         0: begin
            return CHAR_NUL;
         end
         1: begin
            return CHAR_LF;
         end
         default: begin
            return 8'h80 | 8'($urandom_range(127));
         end
      endcase
   endfunction

   // A character inside a frame: a hex digit, or in a broken frame now and then any byte.
   function automatic logic [7:0] frame_char(input bit clean);
      if (!clean && $urandom_range(4) == 0) begin
         return 8'($urandom_range(255));
      end
      return hex_char();
   endfunction

   // Sends a line: some printable junk, ':', the given number of character pairs with the odd
   // dropped character among them, and CR. A broken line may carry stray bytes, an unpaired
   // character or no CR at all, in which case the next line runs on inside the same frame.
   task automatic send_frame(input int pairs, input bit clean);
      int lead;
      lead = $urandom_range(2);
      repeat (lead) begin
         send_char(8'($urandom_range(8'h20, 8'h7E)));
      end
      send_char(CHAR_COLON);
      repeat (pairs) begin
         if ($urandom_range(9) == 0) begin
            send_char(dropped_char());
         end
         send_char(frame_char(clean));
         send_char(frame_char(clean));
      end
      if (!clean && $urandom_range(1) == 1) begin
         send_char(hex_char());
      end
      if (clean || $urandom_range(3) != 0) begin
         send_char(CHAR_CR);
      end
   endtask

   // Opening characters: CR with no frame open, dropped characters including both extremes,
   // junk before the frame start, the hex extremes, a lower-case letter and other non-hex
   // characters, a second ':' as data, dropped characters inside a pair and an unpaired
   // character discarded by the final CR.
   logic [7:0] opening_chars [25] = '{
      CHAR_CR, CHAR_NUL, CHAR_LF, 8'h80, 8'hFF, "x", "7", CHAR_COLON,
      "F", "F", "0", "0", "9", "A", "a", "G", CHAR_COLON, "5",
      "B", CHAR_NUL, "C", CHAR_LF, 8'hC3, "4", CHAR_CR
   };

   initial begin : stimulus
      int idle_by_phase  [4];
      int stall_by_phase [4];
      int pick;
      idle_by_phase  = '{0, 65, 0, 34};
      stall_by_phase = '{0, 0, 65, 34};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_chars[i]) begin
         send_char(opening_chars[i]);
      end
      // The sender pauses here until every result of the opening characters is back.
      wait_for_results();

      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = idle_by_phase[phase];
         receiver_stall_pct = stall_by_phase[phase];
         if (phase == 1) begin
            // A line long enough to wrap the byte count past 255.
            send_frame(262, 1'b1);
         end
         if (phase == 2) begin
            // The receiver holds off for a long stretch while characters keep coming.
            hold_requests++;
            send_frame(20, 1'b1);
         end
         while (counted_chars < (phase + 1) * CHAR_TARGET / 4) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               send_frame($urandom_range(8), 1'b1);
            end else if (pick < 90) begin
               send_frame($urandom_range(8), 1'b0);
            end else begin
               repeat ($urandom_range(1, 6)) begin
                  send_char(8'($urandom_range(255)));
               end
            end
         end
         wait_for_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("ascii_hex_frame_decoder_core_tb passed");
      end else begin
         $display("ascii_hex_frame_decoder_core_tb failed");
      end
      $finish;
   end

endmodule
